// ===== rtl/core/compass_bearing_atan2_defines.svh =====
// Assertion macros for the compass bearing RTL.
`ifndef COMPASS_BEARING_ATAN2_DEFINES_SVH
`define COMPASS_BEARING_ATAN2_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define CBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The expression is never true at a clock edge outside reset.
`define CBA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/core/cba_pkg.sv =====
// Package with the widths, angle constants and types of the compass bearing pipeline.
package cba_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int VEC_W       = 44;
  localparam int ANG_W       = 34;
  localparam int FRAC_BITS   = 16;
  localparam int CENT_W      = ANG_W - FRAC_BITS;
  localparam int OUT_W       = 16;
  localparam int NORM_MSB    = 40;
  localparam int SHAMT_W     = 6;
  localparam int TRUNC_BITS  = 10;
  localparam int RATIO_SHIFT = 20;
  localparam int RATIO_FRAC  = 30;
  localparam int QUOT_BASE   = 34;
  localparam int RAD_W       = 29;

  localparam logic [RAD_W-1:0] RAD_TO_UNITS = 29'd375493621;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd589824000;
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 34'sd2359296000;
  localparam logic signed [ANG_W-1:0] ROUND_HALF   = 34'sd32768;
  localparam logic signed [ANG_W-1:0] WRAP_ROUND   = FULL_TURN + ROUND_HALF;

  localparam int TURN_CENTIDEG = 36000;

  localparam int STEP_TABLE_LEN = 16;
  localparam longint STEP_ANGLE [STEP_TABLE_LEN] = '{
    294912000, 174096719, 91987925, 46694507,
    23437865, 11730358, 5866610, 2933484,
    1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459
  };

  typedef struct packed {
    logic valid;
    logic zero;
  } cba_ctl_t;

  // Rotation angle of one CORDIC step in 1/65536 of a hundredth of a degree.
  function automatic longint cordic_angle(input int idx);
    longint ang;
    ang = 0;
    if (idx < STEP_TABLE_LEN) begin
      ang = STEP_ANGLE[idx];
    end else begin
      ang = (longint'(RAD_TO_UNITS) + (longint'(1) << (idx - 1))) >>> idx;
    end
    return ang;
  endfunction

endpackage

// ===== rtl/core/cba_norm.sv =====
// Input stages: magnitude search, normalising shift and half-plane pre-rotation.
module cba_norm #(
  parameter int SAMPLE_WIDTH = cba_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      y_i,
  output cba_pkg::cba_ctl_t                   ctl_o,
  output logic signed [cba_pkg::VEC_W-1:0]    x_o,
  output logic signed [cba_pkg::VEC_W-1:0]    y_o,
  output logic signed [cba_pkg::ANG_W-1:0]    z_o
);

  localparam int PosW = $clog2(SAMPLE_WIDTH);

  logic [SAMPLE_WIDTH-1:0]              ax, ay, mag;
  logic [PosW-1:0]                      pos;
  logic [cba_pkg::SHAMT_W-1:0]          shamt_d, shamt_q;
  cba_pkg::cba_ctl_t                    ctl_a_d, ctl_a_q, ctl_b_q;
  logic signed [SAMPLE_WIDTH-1:0]       xa_q, ya_q;
  logic signed [cba_pkg::VEC_W-1:0]     xw, yw, xs, ys;
  logic signed [cba_pkg::VEC_W-1:0]     xr_d, yr_d, xr_q, yr_q;
  logic signed [cba_pkg::ANG_W-1:0]     zr_d, zr_q;

  always_comb begin
    ax  = x_i[SAMPLE_WIDTH-1] ? (~x_i + 1'b1) : x_i;
    ay  = y_i[SAMPLE_WIDTH-1] ? (~y_i + 1'b1) : y_i;
    mag = (ax > ay) ? ax : ay;
    pos = '0;
    for (int b = 0; b < SAMPLE_WIDTH; b++) begin
      if (mag[b]) begin
        pos = PosW'(b);
      end
    end
    shamt_d = cba_pkg::SHAMT_W'(cba_pkg::NORM_MSB) - cba_pkg::SHAMT_W'(pos);
    ctl_a_d = '{valid: start_i, zero: (x_i == '0) && (y_i == '0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_a_d;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q    <= x_i;
    ya_q    <= y_i;
    shamt_q <= shamt_d;
  end

  always_comb begin
    xw = cba_pkg::VEC_W'(xa_q);
    yw = cba_pkg::VEC_W'(ya_q);
    xs = xw <<< shamt_q;
    ys = yw <<< shamt_q;
    xr_d = xs;
    yr_d = ys;
    zr_d = '0;
    if (xs[cba_pkg::VEC_W-1]) begin
      if (!ys[cba_pkg::VEC_W-1]) begin
        xr_d = ys;
        yr_d = -xs;
        zr_d = cba_pkg::QUARTER_TURN;
      end else begin
        xr_d = -ys;
        yr_d = xs;
        zr_d = -cba_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    xr_q <= xr_d;
    yr_q <= yr_d;
    zr_q <= zr_d;
  end

  assign ctl_o = ctl_b_q;
  assign x_o   = xr_q;
  assign y_o   = yr_q;
  assign z_o   = zr_q;

endmodule

// ===== rtl/core/cba_cordic_stage.sv =====
// One registered vectoring CORDIC micro-rotation.
module cba_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cba_pkg::cba_ctl_t                ctl_i,
  input  logic signed [cba_pkg::VEC_W-1:0] x_i,
  input  logic signed [cba_pkg::VEC_W-1:0] y_i,
  input  logic signed [cba_pkg::ANG_W-1:0] z_i,
  output cba_pkg::cba_ctl_t                ctl_o,
  output logic signed [cba_pkg::VEC_W-1:0] x_o,
  output logic signed [cba_pkg::VEC_W-1:0] y_o,
  output logic signed [cba_pkg::ANG_W-1:0] z_o
);

  localparam logic signed [cba_pkg::ANG_W-1:0] StepAngle =
    cba_pkg::ANG_W'(cba_pkg::cordic_angle(IDX));

  logic signed [cba_pkg::VEC_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [cba_pkg::ANG_W-1:0] z_d, z_q;
  cba_pkg::cba_ctl_t                ctl_q;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    if (!y_i[cba_pkg::VEC_W-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + StepAngle;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - StepAngle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

// ===== rtl/core/cba_div.sv =====
// Pipelined restoring divider for the residual ratio y/x in Q30 radians.
module cba_div #(
  parameter int QUOT_W = cba_pkg::QUOT_BASE - cba_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cba_pkg::cba_ctl_t                ctl_i,
  input  logic signed [cba_pkg::VEC_W-1:0] x_i,
  input  logic signed [cba_pkg::VEC_W-1:0] y_i,
  input  logic signed [cba_pkg::ANG_W-1:0] z_i,
  output cba_pkg::cba_ctl_t                ctl_o,
  output logic signed [cba_pkg::ANG_W-1:0] z_o,
  output logic [QUOT_W-1:0]                quot_o,
  output logic                             neg_o
);

  localparam int TW = cba_pkg::VEC_W - cba_pkg::TRUNC_BITS;
  localparam int DW = cba_pkg::VEC_W + cba_pkg::RATIO_SHIFT;

  logic signed [cba_pkg::VEC_W-1:0] ts;
  logic                             tpos;
  logic [cba_pkg::VEC_W-1:0]        yabs;
  logic [DW-1:0]                    dvd;

  cba_pkg::cba_ctl_t                ctl_q  [QUOT_W+1];
  logic signed [cba_pkg::ANG_W-1:0] z_q    [QUOT_W+1];
  logic [QUOT_W-1:0]                quot_q [QUOT_W+1];
  logic                             neg_q  [QUOT_W+1];
  logic                             tpos_q [QUOT_W+1];
  logic [TW-1:0]                    t_q    [QUOT_W];
  logic [TW-1:0]                    rem_q  [QUOT_W];
  logic [QUOT_W-1:0]                dl_q   [QUOT_W];

  always_comb begin
    ts   = x_i >>> cba_pkg::TRUNC_BITS;
    tpos = !ts[cba_pkg::VEC_W-1] && (ts != '0);
    yabs = y_i[cba_pkg::VEC_W-1] ? -y_i : y_i;
    dvd  = {yabs, {cba_pkg::RATIO_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q[0]    <= z_i;
    quot_q[0] <= '0;
    neg_q[0]  <= y_i[cba_pkg::VEC_W-1];
    tpos_q[0] <= tpos;
    t_q[0]    <= ts[TW-1:0];
    rem_q[0]  <= dvd[QUOT_W +: TW];
    dl_q[0]   <= dvd[QUOT_W-1:0];
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [TW:0] part, diff;
    logic        ge;

    assign part = {rem_q[k], dl_q[k][QUOT_W-1]};
    assign diff = part - {1'b0, t_q[k]};
    assign ge   = (part >= {1'b0, t_q[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      z_q[k+1]    <= z_q[k];
      quot_q[k+1] <= {quot_q[k][QUOT_W-2:0], ge};
      neg_q[k+1]  <= neg_q[k];
      tpos_q[k+1] <= tpos_q[k];
    end

    if (k < QUOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? diff[TW-1:0] : part[TW-1:0];
        dl_q[k+1]  <= dl_q[k] << 1;
        t_q[k+1]   <= t_q[k];
      end
    end
  end

  assign ctl_o  = ctl_q[QUOT_W];
  assign z_o    = z_q[QUOT_W];
  assign quot_o = tpos_q[QUOT_W] ? quot_q[QUOT_W] : '0;
  assign neg_o  = neg_q[QUOT_W];

endmodule

// ===== rtl/core/cba_finish.sv =====
// Output stages: residual angle scaling, wrap into one turn and rounding to centidegrees.
module cba_finish #(
  parameter int QUOT_W = cba_pkg::QUOT_BASE - cba_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cba_pkg::cba_ctl_t                ctl_i,
  input  logic signed [cba_pkg::ANG_W-1:0] z_i,
  input  logic [QUOT_W-1:0]                quot_i,
  input  logic                             neg_i,
  output logic                             done_o,
  output logic [cba_pkg::OUT_W-1:0]        bearing_o
);

  localparam int ProdW = QUOT_W + cba_pkg::RAD_W;
  localparam int CorrW = ProdW - cba_pkg::RATIO_FRAC;
  localparam logic [cba_pkg::CENT_W-1:0] Turn = cba_pkg::CENT_W'(cba_pkg::TURN_CENTIDEG);

  cba_pkg::cba_ctl_t                ctl1_q, ctl2_q, ctl3_q;
  logic [ProdW-1:0]                 prod_d, prod_q;
  logic signed [cba_pkg::ANG_W-1:0] z1_q;
  logic                             neg1_q;
  logic [CorrW-1:0]                 corr;
  logic signed [cba_pkg::ANG_W-1:0] corr_s, zsum_d, zsum_q, zr;
  logic [cba_pkg::CENT_W-1:0]       cent_d, cent_q, cent_sub;
  logic [cba_pkg::OUT_W-1:0]        bear_d, bear_q;
  logic                             done_q;

  assign prod_d = ProdW'(quot_i) * ProdW'(cba_pkg::RAD_TO_UNITS);

  always_comb begin
    corr   = prod_q[ProdW-1:cba_pkg::RATIO_FRAC];
    corr_s = signed'(cba_pkg::ANG_W'(corr));
    zsum_d = neg1_q ? (z1_q - corr_s) : (z1_q + corr_s);
  end

  always_comb begin
    zr     = zsum_q + (zsum_q[cba_pkg::ANG_W-1] ? cba_pkg::WRAP_ROUND : cba_pkg::ROUND_HALF);
    cent_d = zr[cba_pkg::ANG_W-1] ? '0 : zr[cba_pkg::ANG_W-1:cba_pkg::FRAC_BITS];
  end

  always_comb begin
    cent_sub = cent_q - Turn;
    if (ctl3_q.zero) begin
      bear_d = '0;
    end else if (cent_q >= Turn) begin
      bear_d = (cent_sub >= Turn) ? '0 : cba_pkg::OUT_W'(cent_sub);
    end else begin
      bear_d = cba_pkg::OUT_W'(cent_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      done_q <= ctl3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    z1_q   <= z_i;
    neg1_q <= neg_i;
    zsum_q <= zsum_d;
    cent_q <= cent_d;
    bear_q <= bear_d;
  end

  assign done_o    = done_q;
  assign bearing_o = bear_q;

endmodule

// ===== rtl/core/compass_bearing_atan2.sv =====
// Top level of the pipelined CORDIC compass bearing unit.
//
//   channel   handshake          payload
//   sample    start_i / busy_o   mag_x_i, mag_y_i
//   bearing   done_o             bearing_centideg_o
//
// One item may be started in every clock cycle; busy_o stays low.
// The pipeline is made of these stages:
// two input stages, one stage per CORDIC step, one divider set-up stage,
// one stage per quotient bit of the residual divider and four output stages.
// Reset clears the valid bits of every stage, so items in flight are dropped.
// The result is presented for one cycle with done_o high and is not held.
`include "compass_bearing_atan2_defines.svh"

module compass_bearing_atan2 #(
  parameter int SAMPLE_WIDTH  = cba_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = cba_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_y_i,
  output logic                          done_o,
  output logic [cba_pkg::OUT_W-1:0]     bearing_centideg_o
);

  localparam int QuotW   = cba_pkg::QUOT_BASE - CORDIC_STAGES;
  localparam int Latency = CORDIC_STAGES + QuotW + 7;

  cba_pkg::cba_ctl_t                ctl_c [CORDIC_STAGES+1];
  logic signed [cba_pkg::VEC_W-1:0] x_c   [CORDIC_STAGES+1];
  logic signed [cba_pkg::VEC_W-1:0] y_c   [CORDIC_STAGES+1];
  logic signed [cba_pkg::ANG_W-1:0] z_c   [CORDIC_STAGES+1];

  cba_pkg::cba_ctl_t                ctl_div;
  logic signed [cba_pkg::ANG_W-1:0] z_div;
  logic [QuotW-1:0]                 quot;
  logic                             neg;

  assign busy_o = 1'b0;

  cba_norm #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i && !busy_o),
    .x_i    (mag_x_i),
    .y_i    (mag_y_i),
    .ctl_o  (ctl_c[0]),
    .x_o    (x_c[0]),
    .y_o    (y_c[0]),
    .z_o    (z_c[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    cba_cordic_stage #(
      .IDX(i)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_c[i]),
      .x_i   (x_c[i]),
      .y_i   (y_c[i]),
      .z_i   (z_c[i]),
      .ctl_o (ctl_c[i+1]),
      .x_o   (x_c[i+1]),
      .y_o   (y_c[i+1]),
      .z_o   (z_c[i+1])
    );
  end

  cba_div #(
    .QUOT_W(QuotW)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl_c[CORDIC_STAGES]),
    .x_i   (x_c[CORDIC_STAGES]),
    .y_i   (y_c[CORDIC_STAGES]),
    .z_i   (z_c[CORDIC_STAGES]),
    .ctl_o (ctl_div),
    .z_o   (z_div),
    .quot_o(quot),
    .neg_o (neg)
  );

  cba_finish #(
    .QUOT_W(QuotW)
  ) u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_div),
    .z_i      (z_div),
    .quot_i   (quot),
    .neg_i    (neg),
    .done_o   (done_o),
    .bearing_o(bearing_centideg_o)
  );

  `CBA_NEVER(a_bearing_range, done_o && (bearing_centideg_o >= cba_pkg::OUT_W'(cba_pkg::TURN_CENTIDEG)), "bearing out of range")
  `CBA_ASSERT(a_done_latency, (done_o |-> $past(start_i, Latency)), "result without a started item")
  `CBA_ASSERT(a_zero_vector, (start_i && (mag_x_i == '0) && (mag_y_i == '0) |-> ##Latency (done_o && (bearing_centideg_o == '0))), "zero vector must give zero")

endmodule

// ===== test/tb_compass_bearing_atan2.sv =====
// Self-checking testbench for the pipelined compass bearing unit, with its own bearing predictor.
`timescale 1ns / 100ps

module tb_compass_bearing_atan2;

  localparam int SAMPLE_W     = 16;
  localparam int STAGE_COUNT  = 16;
  localparam int PIPE_LATENCY = 41;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  localparam longint RAD_UNITS    = 64'sd375493621;
  localparam longint NORM_FLOOR   = 64'sd1 << 40;
  localparam longint QUARTER_ANG  = 64'sd9000 << 16;
  localparam longint FULL_ANG     = 64'sd36000 << 16;
  localparam longint ANG_HALF     = 64'sd1 << 15;
  localparam int     TURN_CENT    = 36000;

  localparam longint ATAN_STEP [16] = '{
    294912000, 174096719, 91987925, 46694507,
    23437865, 11730358, 5866610, 2933484,
    1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459
  };

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  logic                       clk_i;
  logic                       rst_ni  = 1'b0;
  logic                       start_i = 1'b0;
  logic signed [SAMPLE_W-1:0] mag_x_i = '0;
  logic signed [SAMPLE_W-1:0] mag_y_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic [cba_pkg::OUT_W-1:0]  bearing_centideg_o;

  logic [cba_pkg::OUT_W-1:0]  pending_bearings [$];
  int                         mismatch_count = 0;
  int                         cycle_count    = 0;

  compass_bearing_atan2 #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .CORDIC_STAGES(STAGE_COUNT)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .mag_x_i           (mag_x_i),
    .mag_y_i           (mag_y_i),
    .done_o            (done_o),
    .bearing_centideg_o(bearing_centideg_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint step_angle(input int idx);
    longint ang;
    if (idx < 16) begin
      ang = ATAN_STEP[idx];
    end else if (idx > 62) begin
      ang = 0;
    end else begin
      ang = (RAD_UNITS + (64'sd1 << (idx - 1))) >>> idx;
    end
    return ang;
  endfunction

  function automatic logic [cba_pkg::OUT_W-1:0] predict_bearing(
    input logic signed [SAMPLE_W-1:0] sx,
    input logic signed [SAMPLE_W-1:0] sy
  );
    longint x, y, z, m, t, dx, dy, ratio, cent;
    int     i;
    x = sx;
    y = sy;
    z = 0;
    if (x == 0 && y == 0) begin
      return '0;
    end
    m = (x < 0) ? -x : x;
    t = (y < 0) ? -y : y;
    if (t > m) begin
      m = t;
    end
    while (m < NORM_FLOOR) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_ANG;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_ANG;
      end
    end
    for (i = 0; i < STAGE_COUNT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + step_angle(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - step_angle(i);
      end
    end
    t = x >>> 10;
    if (t > 0) begin
      ratio = (y * (64'sd1 << 20)) / t;
      z = z + (ratio * RAD_UNITS) / (64'sd1 << 30);
    end
    if (z < 0) begin
      z = z + FULL_ANG;
    end
    if (z < 0) begin
      z = 0;
    end
    cent = (z + ANG_HALF) >>> 16;
    if (cent >= TURN_CENT) begin
      cent = cent - TURN_CENT;
    end
    if (cent < 0 || cent >= TURN_CENT) begin
      cent = 0;
    end
    return cent[cba_pkg::OUT_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    logic [cba_pkg::OUT_W-1:0] want;
    if (rst_ni && done_o) begin
      if (pending_bearings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("Unexpected bearing %0d with no item outstanding", bearing_centideg_o);
        end
      end else begin
        want = pending_bearings.pop_front();
        if (bearing_centideg_o !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("Bearing mismatch: expected %0d, got %0d", want, bearing_centideg_o);
          end
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sx,
                             input logic signed [SAMPLE_W-1:0] sy);
    start_i <= 1'b1;
    mag_x_i <= sx;
    mag_y_i <= sy;
    do begin
      @(posedge clk_i);
    end while (busy_o !== 1'b0);
    pending_bearings.push_back(predict_bearing(sx, sy));
  endtask

  task automatic idle_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_for_bearings();
    start_i <= 1'b0;
    while (pending_bearings.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_component(input int kind);
    logic signed [SAMPLE_W-1:0] v;
    case (kind)
      0: v = SAMPLE_W'($urandom);
      1: v = SAMPLE_W'($signed($urandom_range(16)) - 8);
      2: v = SAMPLE_W'($signed($urandom_range(512)) - 256);
      default: begin
        case ($urandom_range(5))
          0: v = S_MIN;
          1: v = SAMPLE_W'(S_MIN + 1);
          2: v = -1;
          3: v = 0;
          4: v = 1;
          default: v = S_MAX;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic test_axes_and_corners();
    send_sample(0, 0);
    send_sample(-1, 0);
    send_sample(S_MIN, 0);
    send_sample(S_MAX, 0);
    send_sample(1, 0);
    send_sample(0, 1);
    send_sample(0, S_MAX);
    send_sample(0, S_MIN);
    send_sample(0, -1);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MAX, S_MIN);
    send_sample(-1, -1);
    send_sample(1, -1);
    send_sample(-1, 1);
    send_sample(S_MAX, -1);
    send_sample(S_MAX, 1);
    send_sample(S_MIN, -1);
    send_sample(S_MIN, 1);
    send_sample(16'sh5555, 16'shaaaa);
    send_sample(16'shaaaa, 16'sh5555);
    wait_for_bearings();
  endtask

  task automatic test_random_samples(input int count, input int idle_pct);
    int n;
    int kind_x, kind_y;
    for (n = 0; n < count; n++) begin
      kind_x = $urandom_range(3);
      kind_y = ($urandom_range(1) == 0) ? kind_x : $urandom_range(3);
      send_sample(random_component(kind_x), random_component(kind_y));
      idle_gap(idle_pct);
    end
    wait_for_bearings();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_axes_and_corners();
    test_random_samples(120, 0);
    test_random_samples(120, 69);
    test_random_samples(120, 0);
    test_random_samples(120, 19);
    wait_for_bearings();
    repeat (PIPE_LATENCY + 20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_bearings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
